// ===== src/ifmt_pkg.sv =====
`default_nettype none

package ifmt_pkg;

	// Value and digit line sizes
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;
	localparam int FIELD_MAX   = 64;
	localparam int LEN_W       = 7;

	// Digit counts of a full-width magnitude in each base
	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int BIT_W      = $clog2(VALUE_WIDTH);

	// Format flag bit positions
	localparam int FLAG_BIN   = 0;
	localparam int FLAG_OCT   = 1;
	localparam int FLAG_HEX   = 2;
	localparam int FLAG_UNS   = 3;
	localparam int FLAG_SPACE = 4;
	localparam int FLAG_PLUS  = 5;
	localparam int FLAG_ZERO  = 6;
	localparam int FLAG_LEFT  = 7;

	// ASCII codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ALPHA = 8'h57; // 'a' minus ten

	typedef struct packed {
		logic signed [31:0] value;
		logic [7:0]         format_flags;
		logic [6:0]         pad_width;
		logic [6:0]         room;
	} ifmt_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last;
	} ifmt_out_t;

	typedef enum logic [2:0] {
		SEL_NONE,
		SEL_SPACE,
		SEL_SIGN,
		SEL_ZERO,
		SEL_DIGIT
	} char_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_PAD,
		ST_LEAD,
		ST_SIGN,
		ST_ZERO,
		ST_DIGIT,
		ST_TRAIL,
		ST_EMPTY
	} ifmt_state_t;

	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      norm_step;
		logic      calc_pad;
		logic      emit;
		char_sel_t sel;
		logic      has_char;
		logic      last;
		logic      pad_dec;
		logic      dig_adv;
	} ifmt_cmd_t;

	typedef struct packed {
		logic in_dec;
		logic conv_done;
		logic top_zero;
		logic cnt_one;
		logic pad_zero;
		logic pad_one;
		logic rem_one;
		logic room_zero;
		logic has_sign;
		logic zero_pad;
		logic left;
		logic out_free;
	} ifmt_status_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'h0, d};
		end else begin
			r = CH_ALPHA + {4'h0, d};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/ifmt_dp.sv =====
`default_nettype none

module ifmt_dp import ifmt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ifmt_in_t     in_word,
	input  wire ifmt_cmd_t    cmd,
	input  wire logic         out_ready,
	output ifmt_status_t      st,
	output logic              out_valid,
	output ifmt_out_t         out_word
);

	localparam int BASE = MAX_DIGITS - DEC_DIGITS;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BIT_W-1:0]       bcnt_q;
	logic [3:0]             dl_q [MAX_DIGITS];
	logic [CNT_W-1:0]       cnt_q;
	logic [LEN_W-1:0]       wid_q;
	logic [LEN_W-1:0]       rem_q;
	logic [LEN_W-1:0]       pad_q;
	logic                   has_sign_q;
	logic                   zero_q;
	logic                   left_q;
	logic [7:0]             sign_ch_q;
	logic                   out_valid_q;
	ifmt_out_t              out_q;

	logic [VALUE_WIDTH-1:0]  raw;
	logic                    neg;
	logic [VALUE_WIDTH-1:0]  mag_n;
	logic [3*OCT_DIGITS-1:0] ext;
	logic [3:0]              dl_load [MAX_DIGITS];
	logic [3:0]              dl_next [MAX_DIGITS];
	logic [3:0]              adj [DEC_DIGITS];
	logic [CNT_W-1:0]        cnt_load;
	logic [7:0]              flags;
	logic [LEN_W:0]          used;
	logic [LEN_W:0]          wid_ext;
	logic [LEN_W-1:0]        pad_n;
	logic [7:0]              ch;

	assign flags = in_word.format_flags;
	assign raw   = in_word.value[VALUE_WIDTH-1:0];
	assign neg   = !flags[FLAG_UNS] && raw[VALUE_WIDTH-1];
	assign mag_n = neg ? (~raw + 1'b1) : raw;
	assign ext   = (3*OCT_DIGITS)'(mag_n);

	// Top-aligned digit line for the power-of-two bases
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dl_load[i] = 4'h0;
		end
		cnt_load = CNT_W'(DEC_DIGITS);
		if (flags[FLAG_BIN]) begin
			for (int i = 0; i < VALUE_WIDTH; i++) begin
				dl_load[MAX_DIGITS-VALUE_WIDTH+i] = {3'b000, ext[i]};
			end
			cnt_load = CNT_W'(VALUE_WIDTH);
		end else if (flags[FLAG_OCT]) begin
			for (int i = 0; i < OCT_DIGITS; i++) begin
				dl_load[MAX_DIGITS-OCT_DIGITS+i] = {1'b0, ext[3*i +: 3]};
			end
			cnt_load = CNT_W'(OCT_DIGITS);
		end else if (flags[FLAG_HEX]) begin
			for (int i = 0; i < HEX_DIGITS; i++) begin
				dl_load[MAX_DIGITS-HEX_DIGITS+i] = ext[4*i +: 4];
			end
			cnt_load = CNT_W'(HEX_DIGITS);
		end
	end

	// Double dabble on the top decimal digits, plus the one-digit advance
	always_comb begin
		for (int j = 0; j < DEC_DIGITS; j++) begin
			adj[j] = (dl_q[BASE+j] >= 4'd5) ? (dl_q[BASE+j] + 4'd3) : dl_q[BASE+j];
		end
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dl_next[i] = dl_q[i];
		end
		if (cmd.conv_step) begin
			dl_next[BASE] = {adj[0][2:0], mag_q[VALUE_WIDTH-1]};
			for (int j = 1; j < DEC_DIGITS; j++) begin
				dl_next[BASE+j] = {adj[j][2:0], adj[j-1][3]};
			end
		end else if (cmd.norm_step || cmd.dig_adv) begin
			dl_next[0] = 4'h0;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				dl_next[i] = dl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q      <= mag_n;
			has_sign_q <= neg || flags[FLAG_SPACE] || flags[FLAG_PLUS];
			zero_q     <= flags[FLAG_ZERO];
			left_q     <= flags[FLAG_LEFT];
			sign_ch_q  <= neg ? CH_MINUS : (flags[FLAG_SPACE] ? CH_SPACE : CH_PLUS);
			wid_q      <= (in_word.pad_width > LEN_W'(FIELD_MAX)) ?
				LEN_W'(FIELD_MAX) : in_word.pad_width;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dl_q[i] <= dl_load[i];
			end
		end else begin
			if (cmd.conv_step) begin
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			end
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dl_q[i] <= dl_next[i];
			end
		end
	end

	// Pad length once the digit count is final
	assign used    = (LEN_W+1)'(cnt_q) + (LEN_W+1)'(has_sign_q);
	assign wid_ext = (LEN_W+1)'(wid_q);
	assign pad_n   = (wid_ext > used) ? LEN_W'(wid_ext - used) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
			pad_q  <= '0;
		end else begin
			if (cmd.load) begin
				bcnt_q <= '0;
				cnt_q  <= cnt_load;
				rem_q  <= (in_word.room > LEN_W'(FIELD_MAX)) ?
					LEN_W'(FIELD_MAX) : in_word.room;
			end else begin
				if (cmd.conv_step) begin
					bcnt_q <= bcnt_q + 1'b1;
				end
				if (cmd.norm_step || cmd.dig_adv) begin
					cnt_q <= cnt_q - 1'b1;
				end
				if (cmd.emit && cmd.has_char) begin
					rem_q <= rem_q - 1'b1;
				end
			end
			if (cmd.calc_pad) begin
				pad_q <= pad_n;
			end else if (cmd.pad_dec) begin
				pad_q <= pad_q - 1'b1;
			end
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_SPACE: ch = CH_SPACE;
			SEL_SIGN:  ch = sign_ch_q;
			SEL_ZERO:  ch = CH_ZERO;
			SEL_DIGIT: ch = glyph(dl_q[MAX_DIGITS-1]);
			default:   ch = 8'h00;
		endcase
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_char <= ch;
			out_q.has_char <= cmd.has_char;
			out_q.last     <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign st.in_dec    = !(flags[FLAG_BIN] || flags[FLAG_OCT] || flags[FLAG_HEX]);
	assign st.conv_done = (bcnt_q == BIT_W'(VALUE_WIDTH-1));
	assign st.top_zero  = (dl_q[MAX_DIGITS-1] == 4'h0);
	assign st.cnt_one   = (cnt_q == CNT_W'(1));
	assign st.pad_zero  = (pad_q == '0);
	assign st.pad_one   = (pad_q == LEN_W'(1));
	assign st.rem_one   = (rem_q == LEN_W'(1));
	assign st.room_zero = (rem_q == '0);
	assign st.has_sign  = has_sign_q;
	assign st.zero_pad  = zero_q;
	assign st.left      = left_q;
	assign st.out_free  = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ===== src/ifmt_ctrl.sv =====
`default_nettype none

module ifmt_ctrl import ifmt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire ifmt_status_t st,
	output logic              in_ready,
	output ifmt_cmd_t         cmd
);

	ifmt_state_t state_q;
	ifmt_state_t state_n;

	logic lead_on;
	logic zpad_on;
	logic trail_on;

	assign lead_on  = !st.zero_pad && !st.left && !st.pad_zero;
	assign zpad_on  = st.zero_pad && !st.pad_zero;
	assign trail_on = st.left && !st.zero_pad && !st.pad_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = st.in_dec ? ST_CONV : ST_NORM;
				end
			end
			ST_CONV: begin
				if (st.conv_done) begin
					state_n = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!(st.top_zero && !st.cnt_one)) begin
					state_n = ST_PAD;
				end
			end
			ST_PAD: begin
				priority if (st.room_zero) begin
					state_n = ST_EMPTY;
				end else if (lead_on) begin
					state_n = ST_LEAD;
				end else if (st.has_sign) begin
					state_n = ST_SIGN;
				end else if (zpad_on) begin
					state_n = ST_ZERO;
				end else begin
					state_n = ST_DIGIT;
				end
			end
			ST_LEAD: begin
				if (st.out_free) begin
					priority if (st.rem_one) begin
						state_n = ST_IDLE;
					end else if (st.pad_one) begin
						state_n = st.has_sign ? ST_SIGN : ST_DIGIT;
					end
				end
			end
			ST_SIGN: begin
				if (st.out_free) begin
					priority if (st.rem_one) begin
						state_n = ST_IDLE;
					end else if (zpad_on) begin
						state_n = ST_ZERO;
					end else begin
						state_n = ST_DIGIT;
					end
				end
			end
			ST_ZERO: begin
				if (st.out_free) begin
					priority if (st.rem_one) begin
						state_n = ST_IDLE;
					end else if (st.pad_one) begin
						state_n = ST_DIGIT;
					end
				end
			end
			ST_DIGIT: begin
				if (st.out_free) begin
					priority if (st.rem_one) begin
						state_n = ST_IDLE;
					end else if (st.cnt_one) begin
						state_n = trail_on ? ST_TRAIL : ST_IDLE;
					end
				end
			end
			ST_TRAIL: begin
				if (st.out_free && (st.rem_one || st.pad_one)) begin
					state_n = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = SEL_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
			end
			ST_NORM: begin
				if (st.top_zero && !st.cnt_one) begin
					cmd.norm_step = 1'b1;
				end else begin
					cmd.calc_pad = 1'b1;
				end
			end
			ST_PAD: begin
			end
			ST_LEAD: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_SPACE;
					cmd.has_char = 1'b1;
					cmd.last     = st.rem_one;
					cmd.pad_dec  = 1'b1;
				end
			end
			ST_SIGN: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_SIGN;
					cmd.has_char = 1'b1;
					cmd.last     = st.rem_one;
				end
			end
			ST_ZERO: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_ZERO;
					cmd.has_char = 1'b1;
					cmd.last     = st.rem_one;
					cmd.pad_dec  = 1'b1;
				end
			end
			ST_DIGIT: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_DIGIT;
					cmd.has_char = 1'b1;
					cmd.last     = st.rem_one || (st.cnt_one && !trail_on);
					cmd.dig_adv  = 1'b1;
				end
			end
			ST_TRAIL: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_SPACE;
					cmd.has_char = 1'b1;
					cmd.last     = st.rem_one || st.pad_one;
					cmd.pad_dec  = 1'b1;
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_NONE;
					cmd.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
`default_nettype none

// Printf-style integer formatter. Each input word carries a 32-bit value,
// format flags, a minimum field width and the room left at the destination;
// the block answers with one output word per ASCII character: leading
// spaces, sign, zero padding, digits (most significant first, lowercase hex),
// trailing spaces, with last set on the final one. Room zero yields a single
// word with has_char clear and last set. Width and room saturate at 64.
// Timing: an item is accepted, then converted for decimal only (one bit per
// cycle through a double-dabble BCD shifter); then leading zero digits are
// skipped one per cycle (the digit line shifts one digit a cycle until its top
// digit is nonzero or only one digit is left), the pad is sized, the first
// field is picked, and characters are emitted one per cycle, stretched by any
// output stall. The output register lets the next item be accepted while the
// last character of the previous one still waits to be taken.

module integer_to_ascii_formatter import ifmt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ifmt_in_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ifmt_out_t      out_word
);

	ifmt_cmd_t    cmd;
	ifmt_status_t st;

	// Sequencer: decides conversion, normalize and emission steps
	ifmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Digit line, counters and output register
	ifmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.out_ready (out_ready),
		.st        (st),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire
